// File: rtl/rtp_header_parser_defines.svh
// Assertion helpers for the RTP header parser.
`ifndef RTP_HEADER_PARSER_DEFINES_SVH
`define RTP_HEADER_PARSER_DEFINES_SVH

// Check a property at every rising edge outside reset.
`define RHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds.
`define RHP_ASSERT_NEVER(label, cond, msg) \
  `RHP_ASSERT(label, !(cond), msg)

`endif

// File: rtl/rhp_pkg.sv
`default_nettype none

package rhp_pkg;

  localparam int unsigned CountW         = 16;
  localparam int unsigned MaxPacketBytes = 65535;
  localparam int unsigned HdrBytes       = 12;
  localparam int unsigned OutDataW       = 128;

  localparam logic [1:0] VersionRtp = 2'd2;
  localparam int unsigned PaddingBit = 5;
  localparam int unsigned ExtBit     = 4;

  typedef enum logic [2:0] {
    StatusOk,
    StatusShort,
    StatusVersion,
    StatusPadding,
    StatusCsrc,
    StatusExtHeader,
    StatusExtData,
    StatusTooLong
  } status_e;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic              overflow;
    logic [7:0]        first_hdr;
    logic [7:0]        pad_byte;
    logic [15:0]       ext_words;
  } chk_in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
    logic [15:0] length;
  } chk_res_t;

endpackage

`default_nettype wire

// File: rtl/rhp_check.sv
`default_nettype none

module rhp_check (
  input  rhp_pkg::chk_in_t  chk_in_i,
  output rhp_pkg::chk_res_t chk_res_o
);

  logic [16:0] pad_end;
  logic        pad_bad;
  logic        pad_on;
  logic        ext_on;
  logic [15:0] size_adj;
  logic [6:0]  off_base;
  logic [6:0]  ext_hdr_end;
  logic [18:0] ext_end;
  logic [15:0] offset;

  always_comb begin
    pad_on      = chk_in_i.first_hdr[rhp_pkg::PaddingBit];
    ext_on      = chk_in_i.first_hdr[rhp_pkg::ExtBit];
    pad_end     = 17'(chk_in_i.pad_byte) + 17'(rhp_pkg::HdrBytes);
    pad_bad     = pad_end > {1'b0, chk_in_i.byte_count};
    size_adj    = pad_on ? chk_in_i.byte_count - 16'(chk_in_i.pad_byte)
                         : chk_in_i.byte_count;
    off_base    = 7'(rhp_pkg::HdrBytes) + {1'b0, chk_in_i.first_hdr[3:0], 2'b00};
    ext_hdr_end = off_base + 7'd4;
    ext_end     = 19'(ext_hdr_end) + {1'b0, chk_in_i.ext_words, 2'b00};
    offset      = ext_on ? ext_end[15:0] : {9'd0, off_base};

    chk_res_o.offset = offset;
    chk_res_o.length = size_adj - offset;
    chk_res_o.status = rhp_pkg::StatusOk;
    if (chk_in_i.overflow) begin
      chk_res_o.status = rhp_pkg::StatusTooLong;
    end else if (chk_in_i.byte_count < 16'(rhp_pkg::HdrBytes)) begin
      chk_res_o.status = rhp_pkg::StatusShort;
    end else if (chk_in_i.first_hdr[7:6] != rhp_pkg::VersionRtp) begin
      chk_res_o.status = rhp_pkg::StatusVersion;
    end else if (pad_on && pad_bad) begin
      chk_res_o.status = rhp_pkg::StatusPadding;
    end else if (size_adj < {9'd0, off_base}) begin
      chk_res_o.status = rhp_pkg::StatusCsrc;
    end else if (ext_on && (size_adj < {9'd0, ext_hdr_end})) begin
      chk_res_o.status = rhp_pkg::StatusExtHeader;
    end else if (ext_on && ({3'd0, size_adj} < ext_end)) begin
      chk_res_o.status = rhp_pkg::StatusExtData;
    end

    if (chk_res_o.status != rhp_pkg::StatusOk) begin
      chk_res_o.offset = '0;
      chk_res_o.length = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rtp_header_parser.sv
`default_nettype none

// RTP fixed-header parser. Feed a packet one byte per transfer on the slave
// stream, tuser marking the first byte and tlast the final one; one byte is
// taken every cycle while input ready is high. Each packet yields a single
// result transfer, holding status, payload offset and length and the
// captured header fields; the final byte's transfer loads the check stage,
// whose length checks run into the result register. Input ready drops only
// while both the check stage and the result register are held by a stalled
// master side. Packets beyond MAX_PACKET_BYTES report too long.
module rtp_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = rhp_pkg::MaxPacketBytes
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // [7:0] data_byte
  input  wire logic [7:0]                    s_axis_tdata_i,
  // [0] first_byte
  input  wire logic                          s_axis_tuser_i,
  input  wire logic                          s_axis_tlast_i,
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [2:0] status, [18:3] payload_offset, [34:19] payload_length,
  // [50:35] sequence_number, [82:51] rtp_timestamp, [114:83] source_id,
  // [121:115] payload_type, [122] marker, [127:123] zero
  output      logic [rhp_pkg::OutDataW-1:0] m_axis_tdata_o
);

  `include "rtp_header_parser_defines.svh"

  localparam int unsigned CountW = rhp_pkg::CountW;
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_PACKET_BYTES);

  logic [CountW-1:0] cnt_q, cnt_d, cnt_e;
  logic              ovf_q, ovf_d, ovf_e;
  logic [7:0]        b0_q, b0_d, b0_e;
  logic [7:0]        b1_q, b1_d, b1_e;
  logic [15:0]       seq_q, seq_d, seq_e;
  logic [31:0]       ts_q, ts_d, ts_e;
  logic [31:0]       ssrc_q, ssrc_d, ssrc_e;
  logic [15:0]       ext_q, ext_d, ext_e;
  logic [6:0]        ext_at;

  logic              s_xfer;
  logic              out_free;
  logic              p_free;

  logic              p_valid_q;
  rhp_pkg::chk_in_t  p_chk_q;
  logic [7:0]        p_b1_q;
  logic [15:0]       p_seq_q;
  logic [31:0]       p_ts_q;
  logic [31:0]       p_ssrc_q;

  rhp_pkg::chk_res_t chk_res;

  logic              m_valid_q;
  logic [rhp_pkg::OutDataW-1:0] m_data_q;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign p_free          = !p_valid_q || out_free;
  assign s_axis_tready_o = p_free;
  assign s_xfer          = s_axis_tvalid_i && p_free;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_comb begin
    cnt_e  = s_axis_tuser_i ? '0 : cnt_q;
    ovf_e  = s_axis_tuser_i ? 1'b0 : ovf_q;
    b0_e   = s_axis_tuser_i ? '0 : b0_q;
    b1_e   = s_axis_tuser_i ? '0 : b1_q;
    seq_e  = s_axis_tuser_i ? '0 : seq_q;
    ts_e   = s_axis_tuser_i ? '0 : ts_q;
    ssrc_e = s_axis_tuser_i ? '0 : ssrc_q;
    ext_e  = s_axis_tuser_i ? '0 : ext_q;

    cnt_d  = cnt_e;
    ovf_d  = ovf_e;
    b0_d   = b0_e;
    b1_d   = b1_e;
    seq_d  = seq_e;
    ts_d   = ts_e;
    ssrc_d = ssrc_e;
    ext_d  = ext_e;
    ext_at = 7'(rhp_pkg::HdrBytes) + {1'b0, b0_e[3:0], 2'b00} + 7'd2;

    if (cnt_e >= MaxCount) begin
      ovf_d = 1'b1;
    end else begin
      cnt_d = cnt_e + 1'b1;
      if (cnt_e == 16'd0) begin
        b0_d = s_axis_tdata_i;
      end else if (cnt_e == 16'd1) begin
        b1_d = s_axis_tdata_i;
      end else if (cnt_e inside {[16'd2:16'd3]}) begin
        seq_d = {seq_e[7:0], s_axis_tdata_i};
      end else if (cnt_e inside {[16'd4:16'd7]}) begin
        ts_d = {ts_e[23:0], s_axis_tdata_i};
      end else if (cnt_e inside {[16'd8:16'd11]}) begin
        ssrc_d = {ssrc_e[23:0], s_axis_tdata_i};
      end
      if ((cnt_e == {9'd0, ext_at}) || (cnt_e == ({9'd0, ext_at} + 16'd1))) begin
        ext_d = {ext_e[7:0], s_axis_tdata_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      b0_q      <= '0;
      b1_q      <= '0;
      seq_q     <= '0;
      ts_q      <= '0;
      ssrc_q    <= '0;
      ext_q     <= '0;
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_xfer) begin
        if (s_axis_tlast_i) begin
          cnt_q  <= '0;
          ovf_q  <= 1'b0;
          b0_q   <= '0;
          b1_q   <= '0;
          seq_q  <= '0;
          ts_q   <= '0;
          ssrc_q <= '0;
          ext_q  <= '0;
        end else begin
          cnt_q  <= cnt_d;
          ovf_q  <= ovf_d;
          b0_q   <= b0_d;
          b1_q   <= b1_d;
          seq_q  <= seq_d;
          ts_q   <= ts_d;
          ssrc_q <= ssrc_d;
          ext_q  <= ext_d;
        end
      end
      if (p_free) begin
        p_valid_q <= s_xfer && s_axis_tlast_i;
      end
      if (out_free) begin
        m_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && s_axis_tlast_i) begin
      p_chk_q.byte_count <= cnt_d;
      p_chk_q.overflow   <= ovf_d;
      p_chk_q.first_hdr  <= b0_d;
      p_chk_q.pad_byte   <= s_axis_tdata_i;
      p_chk_q.ext_words  <= ext_d;
      p_b1_q             <= b1_d;
      p_seq_q            <= seq_d;
      p_ts_q             <= ts_d;
      p_ssrc_q           <= ssrc_d;
    end
    if (out_free && p_valid_q) begin
      m_data_q <= {5'd0, p_b1_q[7], p_b1_q[6:0], p_ssrc_q, p_ts_q, p_seq_q,
                   chk_res.length, chk_res.offset, chk_res.status};
    end
  end

  rhp_check u_check (
    .chk_in_i  (p_chk_q),
    .chk_res_o (chk_res)
  );

  `RHP_ASSERT(a_last_loads_check, s_xfer && s_axis_tlast_i |=> p_valid_q, "last byte lost")
  `RHP_ASSERT(a_last_clears_count, s_xfer && s_axis_tlast_i |=> cnt_q == '0, "count kept")
  `RHP_ASSERT_NEVER(a_count_bound, cnt_q > MaxCount, "byte count beyond limit")
  `RHP_ASSERT(a_overflow_at_limit, ovf_q |-> cnt_q == MaxCount, "overflow below limit")
  `RHP_ASSERT(a_error_zeroes, m_valid_q && (m_data_q[2:0] != rhp_pkg::StatusOk)
              |-> m_data_q[34:3] == '0, "offset or length set on error")

endmodule

`default_nettype wire

// File: dv/rtp_header_parser_test.sv
module rtp_header_parser_test;

  typedef struct packed {
    logic [4:0]        spare;
    logic              marker;
    logic [6:0]        payload_type;
    logic [31:0]       source_id;
    logic [31:0]       rtp_timestamp;
    logic [15:0]       sequence_number;
    logic [15:0]       payload_length;
    logic [15:0]       payload_offset;
    rhp_pkg::status_e  status;
  } rtp_result_t;

  class rtp_packet_tracker;
    int unsigned count;
    logic        overflow;
    logic [7:0]  first_hdr;
    logic [7:0]  second_hdr;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] ssrc;
    logic [15:0] ext_words;
    rtp_result_t expected_results[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      count = 0;
      overflow = 1'b0;
      first_hdr = '0;
      second_hdr = '0;
      seq = '0;
      stamp = '0;
      ssrc = '0;
      ext_words = '0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function rhp_pkg::status_e evaluate(logic [7:0] pad, output logic [15:0] off_o,
                                        output logic [15:0] len_o);
      int unsigned size;
      int unsigned off;
      int unsigned ext_len;
      size = count;
      off_o = '0;
      len_o = '0;
      if (overflow) return rhp_pkg::StatusTooLong;
      if (size < rhp_pkg::HdrBytes) return rhp_pkg::StatusShort;
      if (first_hdr[7:6] != rhp_pkg::VersionRtp) return rhp_pkg::StatusVersion;
      if (first_hdr[rhp_pkg::PaddingBit]) begin
        if (pad + rhp_pkg::HdrBytes > size) return rhp_pkg::StatusPadding;
        size -= pad;
      end
      off = rhp_pkg::HdrBytes + 4 * first_hdr[3:0];
      if (size < off) return rhp_pkg::StatusCsrc;
      if (first_hdr[rhp_pkg::ExtBit]) begin
        ext_len = 4 * ext_words;
        if (size < off + 4) return rhp_pkg::StatusExtHeader;
        if (size < off + 4 + ext_len) return rhp_pkg::StatusExtData;
        off += 4 + ext_len;
      end
      off_o = off[15:0];
      len_o = 16'(size - off);
      return rhp_pkg::StatusOk;
    endfunction

    function void note_byte(logic [7:0] d, logic is_first, logic is_last);
      int unsigned ext_at;
      rtp_result_t r;
      logic [15:0] off;
      logic [15:0] len;
      if (is_first) clear();
      if (count >= rhp_pkg::MaxPacketBytes) begin
        overflow = 1'b1;
      end else begin
        ext_at = rhp_pkg::HdrBytes + 4 * first_hdr[3:0] + 2;
        if (count == 0) first_hdr = d;
        else if (count == 1) second_hdr = d;
        else if (count <= 3) seq = {seq[7:0], d};
        else if (count <= 7) stamp = {stamp[23:0], d};
        else if (count <= 11) ssrc = {ssrc[23:0], d};
        if (count >= rhp_pkg::HdrBytes && (count == ext_at || count == ext_at + 1))
          ext_words = {ext_words[7:0], d};
        count++;
      end
      if (!is_last) return;
      r.spare = '0;
      r.status = evaluate(d, off, len);
      r.payload_offset = off;
      r.payload_length = len;
      r.sequence_number = seq;
      r.rtp_timestamp = stamp;
      r.source_id = ssrc;
      r.payload_type = second_hdr[6:0];
      r.marker = second_hdr[7];
      expected_results = {expected_results, r};
      clear();
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [rhp_pkg::OutDataW-1:0] data);
      rtp_result_t got;
      rtp_result_t want;
      got = rtp_result_t'(data);
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: 0x%0h", data);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("status", want.status, got.status);
      compare("payload_offset", want.payload_offset, got.payload_offset);
      compare("payload_length", want.payload_length, got.payload_length);
      compare("sequence_number", want.sequence_number, got.sequence_number);
      compare("rtp_timestamp", want.rtp_timestamp, got.rtp_timestamp);
      compare("source_id", want.source_id, got.source_id);
      compare("payload_type", want.payload_type, got.payload_type);
      compare("marker", want.marker, got.marker);
      compare("spare", want.spare, got.spare);
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [7:0]                   s_axis_tdata_i;
  logic                         s_axis_tuser_i;
  logic                         s_axis_tlast_i;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [rhp_pkg::OutDataW-1:0] m_axis_tdata_o;
  int unsigned                  idle_cycles = 0;

  rtp_packet_tracker board = new();

  rtp_header_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= 400) begin
      $display("rtp_header_parser_test: FAIL");
      $finish;
    end
  end

  task automatic send_packet(input logic [7:0] pkt[$], input bit marked, input bit closed,
                             input bit burst);
    int unsigned gap;
    for (int i = 0; i < pkt.size(); i++) begin
      gap = burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid_i = 1'b1;
      s_axis_tdata_i = pkt[i];
      s_axis_tuser_i = marked && (i == 0);
      s_axis_tlast_i = closed && (i == pkt.size() - 1);
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      board.note_byte(s_axis_tdata_i, s_axis_tuser_i, s_axis_tlast_i);
      @(negedge clk_i);
    end
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid_i = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  function automatic void build_packet(ref logic [7:0] pkt[$]);
    int unsigned kind;
    int unsigned cc;
    int unsigned ext_n;
    int unsigned pad_n;
    bit          x;
    bit          p;
    pkt.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 30)) pkt = {pkt, 8'($urandom)};
      return;
    end
    cc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
    x = 1'($urandom);
    p = 1'($urandom);
    pkt = {pkt, {rhp_pkg::VersionRtp, p, x, cc[3:0]}};
    repeat (11 + 4 * cc) pkt = {pkt, 8'($urandom)};
    if (x) begin
      ext_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, 3);
      pkt = {pkt, 8'($urandom)};
      pkt = {pkt, 8'($urandom)};
      pkt = {pkt, ext_n[15:8]};
      pkt = {pkt, ext_n[7:0]};
      if (ext_n <= 3) repeat (4 * ext_n) pkt = {pkt, 8'($urandom)};
    end
    repeat ($urandom_range(0, 24)) pkt = {pkt, 8'($urandom)};
    if (p) begin
      pad_n = $urandom_range(1, 8);
      repeat (pad_n - 1) pkt = {pkt, 8'h00};
      pkt = {pkt, pad_n[7:0]};
    end
    // break the header, truncate, or corrupt the final byte
    if (kind == 1) pkt[0][7:6] = 2'($urandom);
    if (kind == 2) repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
    if (kind == 3) pkt[pkt.size() - 1] = 8'($urandom);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      board.check_result(m_axis_tdata_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [7:0]  pkt[$];
    int unsigned sent;
    int unsigned packets;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = 1'b0;
    s_axis_tlast_i = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    pkt = '{8'hFF};
    send_packet(pkt, 1'b1, 1'b1, 1'b0);
    pkt = '{8'h80, 8'h7F, 8'h12, 8'h34, 8'h56};
    send_packet(pkt, 1'b1, 1'b1, 1'b0);
    pkt = '{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet(pkt, 1'b0, 1'b1, 1'b1);
    hold_until_drained();

    sent = 0;
    packets = 0;
    while (sent < 1550) begin
      build_packet(pkt);
      send_packet(pkt, $urandom_range(0, 7) != 0, $urandom_range(0, 15) != 0,
                  $urandom_range(0, 4) == 0);
      sent += pkt.size();
      packets++;
      if (packets % 40 == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (8) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("rtp_header_parser_test: PASS");
    end else begin
      $display("rtp_header_parser_test: FAIL");
    end
    $finish;
  end

endmodule
